>>> hdl/ecpu_pkg.sv
// Shared types, constants and opcode decode helpers for the eight-bit CPU core.
// Depends on nothing; used by ecpu_alu and eight_bit_cpu_low_opcode_core.
package ecpu_pkg;

  localparam logic [15:0] PC_RESET = 16'h0100;
  localparam logic [7:0]  OP_HALT  = 8'h76;
  localparam logic [7:0]  OP_LDSP  = 8'h08;
  localparam logic [7:0]  OP_RLCA  = 8'h07;
  localparam logic [7:0]  OP_RRCA  = 8'h0F;
  localparam logic [7:0]  OP_RLA   = 8'h17;
  localparam logic [7:0]  OP_RRA   = 8'h1F;
  localparam logic [7:0]  OP_DAA   = 8'h27;
  localparam logic [7:0]  OP_CPL   = 8'h2F;
  localparam logic [7:0]  OP_SCF   = 8'h37;
  localparam logic [7:0]  OP_CCF   = 8'h3F;
  localparam logic [7:0]  OP_JR    = 8'h18;
  localparam logic [7:0]  OP_JRNZ  = 8'h20;
  localparam logic [7:0]  OP_JRZ   = 8'h28;
  localparam logic [7:0]  OP_JRNC  = 8'h30;
  localparam logic [7:0]  OP_JRC   = 8'h38;
  localparam logic [2:0]  R_MEM    = 3'd6;
  localparam logic        CMD_LOAD = 1'b0;

  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  typedef struct packed {
    logic [7:0]  a;
    logic [3:0]  f;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [15:0] pc;
  } regs_t;

  typedef struct packed {
    logic        en;
    logic [15:0] addr;
    logic [7:0]  data;
  } memwr_t;

  function automatic logic is_unsupported(logic [7:0] op);
    is_unsupported = (op == OP_HALT) || op[7];
  endfunction

  function automatic logic [1:0] imm_count(logic [7:0] op);
    imm_count = 2'd0;
    if (op[7:6] == 2'b00) begin
      if (op[2:0] == 3'd6 || op == OP_JR || op == OP_JRNZ || op == OP_JRZ ||
          op == OP_JRNC || op == OP_JRC) begin
        imm_count = 2'd1;
      end else if (op[3:0] == 4'h1 || op == OP_LDSP) begin
        imm_count = 2'd2;
      end
    end
  endfunction

  function automatic logic needs_read(logic [7:0] op);
    needs_read = 1'b0;
    if (op[7:6] != 2'b00) begin
      needs_read = (op[2:0] == R_MEM);
    end else if ((op[2:0] == 3'd4 || op[2:0] == 3'd5) && op[5:3] == R_MEM) begin
      needs_read = 1'b1;
    end else if (op[3:0] == 4'hA) begin
      needs_read = 1'b1;
    end
  endfunction

  function automatic logic [15:0] read_addr(logic [7:0] op, regs_t r);
    read_addr = r.hl;
    if (op[7:6] == 2'b00 && op[3:0] == 4'hA && !op[5]) begin
      read_addr = op[4] ? r.de : r.bc;
    end
  endfunction

endpackage

>>> hdl/eight_bit_cpu_low_opcode_core.sv
// Top level of the eight-bit CPU core: input buffer, sequencer, registers, result register.
// Depends on ecpu_pkg, ecpu_mem and ecpu_alu.
//
// Input stream (s_axis): one transfer is either a load (write one byte to the core's
// memory) or an execute (fetch and run the opcode at pc). Output stream (m_axis): one
// transfer per input with the M-cycle count, unsupported flag and all registers.
// A load writes its byte as it is taken from the buffer, then goes to the result state.
// An execute has a state to take the transfer from the buffer, one memory read each for the opcode
// and up to two immediate bytes or one data read, an execute state that may write one
// byte, a second write state for LD (a16),SP, and a result state.
// The single read port and single write port of the byte memory set this sequence.
// An input buffer takes the next transfer while the current one runs, and the result
// register holds a result while the receiver stalls; the sequencer waits for it.
// After reset the memory is swept to zero, one byte a cycle over all 2**MEM_ADDR_BITS
// addresses, while s_axis_tready stays low. Registers reset to zero, pc to 0x0100.
// Memory addresses are taken modulo 2**MEM_ADDR_BITS.
module eight_bit_cpu_low_opcode_core #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // command[0], address[16:1], data[24:17], zero[31:25]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata   // cycles[2:0], unsupported[3], pc[19:4], reg_a[27:20],
                                     // reg_flags[31:28], reg_bc[47:32], reg_de[63:48],
                                     // reg_hl[79:64], reg_sp[95:80]
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_IMM1, S_IMM2, S_DRD, S_EXEC, S_WR2, S_DONE
  } state_t;

  state_t                 state;
  logic [MEM_ADDR_BITS-1:0] clr;
  logic                   ibuf_valid;
  logic                   ibuf_cmd;
  logic [15:0]            ibuf_addr;
  logic [7:0]             ibuf_data;
  ecpu_pkg::regs_t        regs;
  logic [7:0]             op;
  logic [15:0]            imm;
  logic [7:0]             mbyte;
  logic [1:0]             imm_left;
  logic [2:0]             cyc;
  logic                   uns;
  logic                   out_valid;
  logic [95:0]            out_data;

  ecpu_pkg::memwr_t       mwr;
  logic [15:0]            raddr;
  logic [7:0]             rdata;
  logic [15:0]            a16_next;

  ecpu_pkg::regs_t        alu_regs;
  ecpu_pkg::memwr_t       alu_wr;
  logic                   alu_wr2;
  logic [2:0]             alu_cyc;

  ecpu_alu u_alu (
    .op    (op),
    .r     (regs),
    .imm   (imm),
    .mbyte (mbyte),
    .n     (alu_regs),
    .wr    (alu_wr),
    .wr2   (alu_wr2),
    .cyc   (alu_cyc)
  );

  ecpu_mem #(.ADDR_BITS(MEM_ADDR_BITS)) u_mem (
    .clk     (clk),
    .wr_en   (mwr.en),
    .wr_addr (mwr.addr[MEM_ADDR_BITS-1:0]),
    .wr_data (mwr.data),
    .rd_addr (raddr[MEM_ADDR_BITS-1:0]),
    .rd_data (rdata)
  );

  assign a16_next      = imm + 16'd1;
  assign s_axis_tready = !ibuf_valid && state != S_CLEAR;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_comb begin
    mwr   = '0;
    raddr = regs.pc;
    unique case (state)
      S_CLEAR: mwr = '{en: 1'b1, addr: 16'(clr), data: 8'd0};
      S_IDLE:  mwr = '{en: ibuf_valid && ibuf_cmd == ecpu_pkg::CMD_LOAD,
                       addr: ibuf_addr, data: ibuf_data};
      S_FETCH: raddr = (ecpu_pkg::imm_count(rdata) != 2'd0) ? regs.pc + 16'd1
                                                             : ecpu_pkg::read_addr(rdata, regs);
      S_IMM1:  raddr = regs.pc + 16'd1;
      S_EXEC:  mwr = alu_wr;
      S_WR2:   mwr = '{en: 1'b1, addr: a16_next, data: regs.sp[15:8]};
      default: raddr = regs.pc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      ibuf_valid <= 1'b0;
      out_valid  <= 1'b0;
      regs       <= '{a: 8'd0, f: 4'd0, bc: 16'd0, de: 16'd0, hl: 16'd0, sp: 16'd0,
                      pc: ecpu_pkg::PC_RESET};
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        ibuf_valid <= 1'b1;
        ibuf_cmd   <= s_axis_tdata[0];
        ibuf_addr  <= s_axis_tdata[16:1];
        ibuf_data  <= s_axis_tdata[24:17];
      end
      if (out_valid && m_axis_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (&clr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (ibuf_valid) begin
            ibuf_valid <= 1'b0;
            cyc        <= 3'd0;
            uns        <= 1'b0;
            state      <= (ibuf_cmd == ecpu_pkg::CMD_LOAD) ? S_DONE : S_FETCH;
          end
        end
        S_FETCH: begin
          op       <= rdata;
          imm_left <= ecpu_pkg::imm_count(rdata);
          if (ecpu_pkg::is_unsupported(rdata)) begin
            uns   <= 1'b1;
            state <= S_DONE;
          end else begin
            regs.pc <= regs.pc + 16'd1;
            priority if (ecpu_pkg::imm_count(rdata) != 2'd0) begin
              state <= S_IMM1;
            end else if (ecpu_pkg::needs_read(rdata)) begin
              state <= S_DRD;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_IMM1: begin
          imm     <= {8'd0, rdata};
          regs.pc <= regs.pc + 16'd1;
          state   <= (imm_left == 2'd2) ? S_IMM2 : S_EXEC;
        end
        S_IMM2: begin
          imm[15:8] <= rdata;
          regs.pc   <= regs.pc + 16'd1;
          state     <= S_EXEC;
        end
        S_DRD: begin
          mbyte <= rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          regs  <= alu_regs;
          cyc   <= alu_cyc;
          state <= alu_wr2 ? S_WR2 : S_DONE;
        end
        S_WR2: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_data  <= {regs.sp, regs.hl, regs.de, regs.bc, regs.f, regs.a, regs.pc,
                          uns, cyc};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !s_axis_tready)
    else $error("input accepted during memory clear");

  a_uns_no_cycles: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:0] == 3'd0)
    else $error("unsupported result with nonzero cycles");

  a_uns_pc_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH && ecpu_pkg::is_unsupported(rdata) |=> $stable(regs.pc))
    else $error("pc moved on unsupported opcode");

endmodule

>>> hdl/ecpu_mem.sv
// Single-port-write, single-port-read byte memory with registered read data.
// No dependencies.
module ecpu_mem #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [7:0]           wr_data,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [7:0]           rd_data
);

  logic [7:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/ecpu_alu.sv
// Execute stage: computes new registers, memory write and M-cycle count for one opcode.
// Depends on ecpu_pkg.
module ecpu_alu (
  input  logic [7:0]         op,
  input  ecpu_pkg::regs_t    r,
  input  logic [15:0]        imm,
  input  logic [7:0]         mbyte,
  output ecpu_pkg::regs_t    n,
  output ecpu_pkg::memwr_t   wr,
  output logic               wr2,
  output logic [2:0]         cyc
);

  logic [7:0]  v;
  logic [7:0]  da;
  logic        cy;
  logic        take;
  logic [15:0] p;
  logic [15:0] addr;
  logic [16:0] sum;
  logic [12:0] hsum;

  function automatic logic [7:0] rd8(ecpu_pkg::regs_t x, logic [2:0] i, logic [7:0] m);
    unique case (i)
      3'd0:    rd8 = x.bc[15:8];
      3'd1:    rd8 = x.bc[7:0];
      3'd2:    rd8 = x.de[15:8];
      3'd3:    rd8 = x.de[7:0];
      3'd4:    rd8 = x.hl[15:8];
      3'd5:    rd8 = x.hl[7:0];
      3'd6:    rd8 = m;
      default: rd8 = x.a;
    endcase
  endfunction

  function automatic ecpu_pkg::regs_t wr8(ecpu_pkg::regs_t x, logic [2:0] i, logic [7:0] d);
    wr8 = x;
    unique case (i)
      3'd0:    wr8.bc[15:8] = d;
      3'd1:    wr8.bc[7:0]  = d;
      3'd2:    wr8.de[15:8] = d;
      3'd3:    wr8.de[7:0]  = d;
      3'd4:    wr8.hl[15:8] = d;
      3'd5:    wr8.hl[7:0]  = d;
      3'd6:    wr8 = x;
      default: wr8.a = d;
    endcase
  endfunction

  function automatic logic [15:0] rdp(ecpu_pkg::regs_t x, logic [1:0] i);
    unique case (i)
      2'd0:    rdp = x.bc;
      2'd1:    rdp = x.de;
      2'd2:    rdp = x.hl;
      default: rdp = x.sp;
    endcase
  endfunction

  function automatic ecpu_pkg::regs_t wrp(ecpu_pkg::regs_t x, logic [1:0] i, logic [15:0] d);
    wrp = x;
    unique case (i)
      2'd0:    wrp.bc = d;
      2'd1:    wrp.de = d;
      2'd2:    wrp.hl = d;
      default: wrp.sp = d;
    endcase
  endfunction

  always_comb begin
    n    = r;
    wr   = '0;
    wr2  = 1'b0;
    cyc  = 3'd1;
    v    = '0;
    da   = r.a;
    cy   = r.f[ecpu_pkg::FLAG_C];
    take = 1'b0;
    p    = rdp(r, op[5:4]);
    addr = r.hl;
    sum  = '0;
    hsum = '0;
    priority if (op[7:6] != 2'b00) begin
      v = rd8(r, op[2:0], mbyte);
      n = wr8(r, op[5:3], v);
      wr = '{en: (op[5:3] == ecpu_pkg::R_MEM), addr: r.hl, data: v};
      cyc = (op[5:3] == ecpu_pkg::R_MEM || op[2:0] == ecpu_pkg::R_MEM) ? 3'd2 : 3'd1;
    end else if (op[2:0] == 3'd4 || op[2:0] == 3'd5) begin
      v = op[0] ? rd8(r, op[5:3], mbyte) - 8'd1 : rd8(r, op[5:3], mbyte) + 8'd1;
      n = wr8(r, op[5:3], v);
      wr = '{en: (op[5:3] == ecpu_pkg::R_MEM), addr: r.hl, data: v};
      n.f = {v == 8'd0, op[0], op[0] ? (v[3:0] == 4'hF) : (v[3:0] == 4'h0),
             r.f[ecpu_pkg::FLAG_C]};
      cyc = (op[5:3] == ecpu_pkg::R_MEM) ? 3'd3 : 3'd1;
    end else if (op[2:0] == 3'd6) begin
      v = imm[7:0];
      n = wr8(r, op[5:3], v);
      wr = '{en: (op[5:3] == ecpu_pkg::R_MEM), addr: r.hl, data: v};
      cyc = (op[5:3] == ecpu_pkg::R_MEM) ? 3'd3 : 3'd2;
    end else if (op[3:0] == 4'h1) begin
      n = wrp(r, op[5:4], imm);
      cyc = 3'd3;
    end else if (op[3:0] == 4'h3 || op[3:0] == 4'hB) begin
      n = wrp(r, op[5:4], op[3] ? p - 16'd1 : p + 16'd1);
      cyc = 3'd2;
    end else if (op[3:0] == 4'h9) begin
      sum  = {1'b0, r.hl} + {1'b0, p};
      hsum = {1'b0, r.hl[11:0]} + {1'b0, p[11:0]};
      n.hl = sum[15:0];
      n.f  = {r.f[ecpu_pkg::FLAG_Z], 1'b0, hsum[12], sum[16]};
      cyc  = 3'd2;
    end else if (op[3:0] == 4'h2 || op[3:0] == 4'hA) begin
      addr = op[5] ? r.hl : p;
      if (op[3]) begin
        n.a = mbyte;
      end else begin
        wr = '{en: 1'b1, addr: addr, data: r.a};
      end
      if (op[5:4] == 2'd2) begin
        n.hl = r.hl + 16'd1;
      end else if (op[5:4] == 2'd3) begin
        n.hl = r.hl - 16'd1;
      end
      cyc = 3'd2;
    end else begin
      unique case (op)
        ecpu_pkg::OP_RLCA: begin
          n.a = {r.a[6:0], r.a[7]};
          n.f = {3'b000, r.a[7]};
        end
        ecpu_pkg::OP_RRCA: begin
          n.a = {r.a[0], r.a[7:1]};
          n.f = {3'b000, r.a[0]};
        end
        ecpu_pkg::OP_RLA: begin
          n.a = {r.a[6:0], r.f[ecpu_pkg::FLAG_C]};
          n.f = {3'b000, r.a[7]};
        end
        ecpu_pkg::OP_RRA: begin
          n.a = {r.f[ecpu_pkg::FLAG_C], r.a[7:1]};
          n.f = {3'b000, r.a[0]};
        end
        ecpu_pkg::OP_DAA: begin
          if (!r.f[ecpu_pkg::FLAG_N]) begin
            if (cy || r.a > 8'h99) begin
              da = r.a + 8'h60;
              cy = 1'b1;
            end
            if (r.f[ecpu_pkg::FLAG_H] || da[3:0] > 4'd9) begin
              da = da + 8'h06;
            end
          end else begin
            if (cy) begin
              da = da - 8'h60;
            end
            if (r.f[ecpu_pkg::FLAG_H]) begin
              da = da - 8'h06;
            end
          end
          n.a = da;
          n.f = {da == 8'd0, r.f[ecpu_pkg::FLAG_N], 1'b0, cy};
        end
        ecpu_pkg::OP_CPL: begin
          n.a = ~r.a;
          n.f = r.f | 4'b0110;
        end
        ecpu_pkg::OP_SCF: n.f = {r.f[ecpu_pkg::FLAG_Z], 3'b001};
        ecpu_pkg::OP_CCF: n.f = {r.f[ecpu_pkg::FLAG_Z], 2'b00, ~r.f[ecpu_pkg::FLAG_C]};
        ecpu_pkg::OP_LDSP: begin
          wr  = '{en: 1'b1, addr: imm, data: r.sp[7:0]};
          wr2 = 1'b1;
          cyc = 3'd5;
        end
        ecpu_pkg::OP_JR, ecpu_pkg::OP_JRNZ, ecpu_pkg::OP_JRZ,
        ecpu_pkg::OP_JRNC, ecpu_pkg::OP_JRC: begin
          unique case (op)
            ecpu_pkg::OP_JRNZ: take = !r.f[ecpu_pkg::FLAG_Z];
            ecpu_pkg::OP_JRZ:  take = r.f[ecpu_pkg::FLAG_Z];
            ecpu_pkg::OP_JRNC: take = !r.f[ecpu_pkg::FLAG_C];
            ecpu_pkg::OP_JRC:  take = r.f[ecpu_pkg::FLAG_C];
            default:           take = 1'b1;
          endcase
          if (take) begin
            n.pc = r.pc + {{8{imm[7]}}, imm[7:0]};
          end
          cyc = take ? 3'd3 : 3'd2;
        end
        default: cyc = 3'd1;
      endcase
    end
  end

endmodule
